// ===== design/msl_pkg.sv =====
// ----------------------------------------------------------------------------
// msl_pkg
// Shared types and constants of the monotone subsequence length core.
// ----------------------------------------------------------------------------
package msl_pkg;

  // Width of the sequence values and of the reported lengths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 11;

  // Flipping the sign bit turns a two's complement value into an
  // offset-binary key that orders correctly as an unsigned number.
  localparam logic [DATA_W-1:0] KEY_SIGN = {1'b1, {(DATA_W-1){1'b0}}};

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT     = 1'd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] ending_length;
    logic [LEN_W-1:0] best_length;
    logic             overflow;
    logic             last_out;
  } out_item_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    logic [DATA_W-1:0] key;   // offset-binary key, stored as a tail
    logic [DATA_W-1:0] cmp;   // key in the comparison space of the order
    logic              last;
  } q_entry_t;

  typedef struct packed {
    logic descending;
    logic strict_order;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SRCH,
    BK_DONE
  } back_state_e;

endpackage

// ===== design/msl_ram.sv =====
// ----------------------------------------------------------------------------
// msl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/msl_fifo.sv =====
// ----------------------------------------------------------------------------
// msl_fifo
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module msl_fifo
  import msl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  output logic     ready_o,
  input  logic     pop_i,
  output q_entry_t pop_data_o,
  output logic     valid_o
);

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o    = (cnt_q != 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/msl_front.sv =====
// ----------------------------------------------------------------------------
// msl_front
// Configuration registers and input classification into search keys.
// ----------------------------------------------------------------------------
module msl_front
  import msl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_wdata_i,
  input  in_item_t             in_data_i,
  output q_entry_t             entry_o,
  output cfg_t                 cfg_o
);

  logic              desc_q;
  logic              strict_q;
  logic [DATA_W-1:0] key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q   <= 1'b0;
      strict_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DESCENDING: desc_q   <= cfg_wdata_i;
        CFG_STRICT:     strict_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A descending order is the ascending order on inverted keys.
  assign key           = $unsigned(in_data_i.value) ^ KEY_SIGN;
  assign entry_o.key   = key;
  assign entry_o.cmp   = desc_q ? ~key : key;
  assign entry_o.last  = in_data_i.last;

  assign cfg_o.descending   = desc_q;
  assign cfg_o.strict_order = strict_q;

endmodule

// ===== design/msl_back.sv =====
// ----------------------------------------------------------------------------
// msl_back
// Binary search over the tail store, tail update and result register.
// ----------------------------------------------------------------------------
module msl_back
  import msl_pkg::*;
#(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  q_entry_t  q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] MaxLen = CW'(MAX_LEN);

  back_state_e state_q, state_d;

  logic [CW-1:0]     count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [CW-1:0]     lo_q, lo_d;
  logic [CW-1:0]     hi_q, hi_d;
  logic [AW-1:0]     mid_q, mid_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic [DATA_W-1:0] cmp_q, cmp_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;

  logic [DATA_W-1:0] tail;
  logic              go_right;
  logic [CW-1:0]     lo_n, hi_n, mid_n;
  logic              out_free;
  logic              replace, extend;
  logic [CW-1:0]     ending;
  logic [CW+LEN_W-1:0] ending_ext, count_ext;

  msl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (lo_q[AW-1:0]),
    .wr_data_i (key_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // One search step: compare the tail read last cycle and narrow [lo, hi).
  assign tail     = cfg_i.descending ? ~rd_data : rd_data;
  assign go_right = cfg_i.strict_order ? (tail < cmp_q) : (tail <= cmp_q);
  assign lo_n     = go_right ? (CW'(mid_q) + CW'(1)) : lo_q;
  assign hi_n     = go_right ? hi_q : CW'(mid_q);
  assign mid_n    = lo_n + ((hi_n - lo_n) >> 1);

  assign out_free = !out_valid_q || out_ready_i;
  assign replace  = (lo_q < count_q);
  assign extend   = !replace && (count_q < MaxLen);

  always_comb begin
    if (replace) begin
      ending = lo_q + CW'(1);
    end else if (extend) begin
      ending = count_q + CW'(1);
    end else begin
      ending = MaxLen;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = (count_q == '0) ? BK_DONE : BK_SRCH;
        end
      end
      BK_SRCH: begin
        if (!(lo_n < hi_n)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    cmp_d       = cmp_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = mid_n[AW-1:0];
    wr_en       = 1'b0;
    count_ext   = '0;
    ending_ext  = '0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          key_d   = q_data_i.key;
          cmp_d   = q_data_i.cmp;
          last_d  = q_data_i.last;
          lo_d    = '0;
          hi_d    = count_q;
          mid_d   = count_q[CW-1:1];
          rd_addr = count_q[CW-1:1];
          rd_en   = (count_q != '0);
        end
      end
      BK_SRCH: begin
        lo_d  = lo_n;
        hi_d  = hi_n;
        mid_d = mid_n[AW-1:0];
        rd_en = (lo_n < hi_n);
      end
      BK_DONE: begin
        if (out_free) begin
          wr_en       = replace || extend;
          count_d     = extend ? (count_q + CW'(1)) : count_q;
          ovf_d       = ovf_q || !(replace || extend);
          count_ext   = {{LEN_W{1'b0}}, count_d};
          ending_ext  = {{LEN_W{1'b0}}, ending};
          out_d.ending_length = ending_ext[LEN_W-1:0];
          out_d.best_length   = count_ext[LEN_W-1:0];
          out_d.overflow      = ovf_d;
          out_d.last_out      = last_q;
          out_valid_d         = 1'b1;
          if (last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    key_q  <= key_d;
    cmp_q  <= cmp_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/monotone_subsequence_length_core.sv =====
// ----------------------------------------------------------------------------
// monotone_subsequence_length_core
// Streaming longest monotone subsequence length (patience sorting).
// ----------------------------------------------------------------------------
// Usage: values enter on the input channel (valid/ready) as signed words with
// a last flag. Every input transfer yields exactly one output transfer that
// carries the length of the best subsequence ending at that value, the best
// length so far, a sticky overflow flag and the echoed last flag. After a
// result with last set, the tail store is logically empty again.
// The configuration port selects ascending or descending and strict or
// non-strict order; write it only while the block is idle.
// Search: on an idle pipeline the back end pops the queue in the cycle after
// the input transfer, then takes at most ceil(log2(n + 1)) binary search
// steps over n stored tails: one tail memory read per cycle, compared as it
// returns. An empty store skips the search. The tail and the result are
// written once the result register is free, and only then does the back end
// take the next item from the queue.
// A two-entry queue lets the input side keep accepting while the back end
// searches, and the result register lets the next search run while a result
// waits. When the receiver stalls, the back end holds its finished item and
// the queue fills, after which input ready drops.
// Reset empties the store (count to zero), clears overflow and sets the
// configuration to ascending, strict. The tail memory itself is not cleared.
// ----------------------------------------------------------------------------
module monotone_subsequence_length_core
  import msl_pkg::*;
#(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_wdata_i
);

  q_entry_t entry;
  q_entry_t q_data;
  cfg_t     cfg;
  logic     q_valid;
  logic     q_pop;

  // Front: configuration and key classification.
  msl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .entry_o     (entry),
    .cfg_o       (cfg)
  );

  // Queue between front and back; its free space is the input ready.
  msl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (entry),
    .ready_o     (in_ready_o),
    .pop_i       (q_pop),
    .pop_data_o  (q_data),
    .valid_o     (q_valid)
  );

  // Back: search, tail update and output register.
  msl_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/msl_chk.sv =====
// ----------------------------------------------------------------------------
// msl_chk
// Port-level checks of the core, bound to the top level.
// ----------------------------------------------------------------------------
module msl_chk
  import msl_pkg::*;
#(
  parameter int unsigned MAX_LEN = 1024
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input in_item_t             in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input out_item_t            out_data_o,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic                 cfg_wdata_i
);

  localparam bit NoWrap = (MAX_LEN < (1 << LEN_W));

  // Set while the next result opens a new sequence.
  logic seq_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_start_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      seq_start_q <= out_data_o.last_out;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before its transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_first_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seq_start_q |->
      out_data_o.ending_length == LEN_W'(1) && out_data_o.best_length == LEN_W'(1)
      && !out_data_o.overflow)
    else $error("first result of a sequence is not length one");

  a_ending_le_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NoWrap && out_valid_o |->
      out_data_o.ending_length <= out_data_o.best_length
      && out_data_o.ending_length != '0)
    else $error("ending length exceeds best length");

endmodule

bind monotone_subsequence_length_core msl_chk #(.MAX_LEN(MAX_LEN)) u_msl_chk (.*);

// ===== tb/monotone_subsequence_length_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monotone_subsequence_length_core_tb
// Self-checking bench for the streaming longest monotone subsequence core.
// ----------------------------------------------------------------------------
// Values are pushed through the input channel and every output transfer is
// compared field by field against a patience-sorting tracker kept inside the
// bench. Directed tests hit the value extremes, equal values in both strict
// and non-strict order, the descending order, an order change in the middle
// of a sequence and a completely filled tail store. A long receiver stall
// backs the core up until it drops input ready, and four random phases walk
// through every order setting with mixed sequences and random idling.
// ----------------------------------------------------------------------------
module monotone_subsequence_length_core_tb;
  import msl_pkg::*;

  localparam int MAX_LEN      = 1024;
  // Covers a search over a full store, plus the front queue.
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 30;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_DESCENDING;
  logic                 cfg_wdata_i = 1'b0;

  monotone_subsequence_length_core #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the core state: the tail keys in offset binary, the
  // number of valid tails, the sticky overflow and both order settings.
  logic [DATA_W-1:0] tail_keys [MAX_LEN];
  int                tail_total    = 0;
  bit                store_full    = 1'b0;
  bit                order_desc    = 1'b0;
  bit                order_strict  = 1'b1;

  // Results predicted for accepted inputs, oldest first.
  out_item_t         pending_lengths[$];

  // Bookkeeping shared by the stimulus, the receiver and the checker.
  bit                idle_on       = 1'b1;
  bit                hold_request  = 1'b0;
  int                error_count   = 0;
  int                items_sent    = 0;
  int                results_seen  = 0;
  int                overflow_hits = 0;
  int                longest_seen  = 0;
  int                cycle_count   = 0;

  // In descending order the keys are complemented so that one unsigned
  // comparison serves both orders.
  function automatic logic [DATA_W-1:0] rank_of(input logic [DATA_W-1:0] key);
    return order_desc ? ~key : key;
  endfunction

  // Patience sorting step: binary search for the first tail the value does
  // not beat, then replace it or append past the end. A full store leaves
  // the tails alone, pins the length at MAX_LEN and raises the sticky flag.
  function automatic out_item_t track_tails(input in_item_t item);
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] probe;
    logic [DATA_W-1:0] tail;
    int                lo;
    int                hi;
    int                mid;
    int                ending;
    bit                go_right;
    out_item_t         res;
    key   = item.value ^ KEY_SIGN;
    probe = rank_of(key);
    lo    = 0;
    hi    = tail_total;
    while (lo < hi) begin
      mid      = lo + (hi - lo) / 2;
      tail     = rank_of(tail_keys[mid]);
      go_right = order_strict ? (tail < probe) : (tail <= probe);
      if (go_right) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (lo < tail_total) begin
      tail_keys[lo] = key;
      ending        = lo + 1;
    end else if (tail_total < MAX_LEN) begin
      tail_keys[tail_total] = key;
      tail_total++;
      ending = tail_total;
    end else begin
      store_full = 1'b1;
      ending     = MAX_LEN;
    end
    res.ending_length = LEN_W'(ending);
    res.best_length   = LEN_W'(tail_total);
    res.overflow      = store_full;
    res.last_out      = item.last;
    // The closing element of a sequence empties the store for the next one.
    if (item.last) begin
      tail_total = 0;
      store_full = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Offers one value on the input channel and records its predicted result
  // once the transfer happens. Valid is only lowered ahead of a gap, so a
  // back-to-back item keeps it high from one transfer to the next.
  task automatic send_item(input logic signed [DATA_W-1:0] value, input logic last);
    int       gap;
    in_item_t pkt;
    gap       = idle_on ? $urandom_range(0, 12) : 0;
    pkt.value = value;
    pkt.last  = last;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= pkt;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_lengths = {pending_lengths, track_tails(pkt)};
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every predicted result has come back, then
  // lets the back end run out before anything touches the configuration.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_lengths.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Writes both order registers on consecutive cycles. Only called while
  // the core is idle, so the shadow settings can follow at once.
  task automatic set_order(input bit desc, input bit strict);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DESCENDING;
    cfg_wdata_i <= desc;
    @(negedge clk_i);
    cfg_index_i <= CFG_STRICT;
    cfg_wdata_i <= strict;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    order_desc   = desc;
    order_strict = strict;
  endtask

  // Most negative, most positive, around zero, and a repeat of the maximum
  // which in strict order must replace rather than extend.
  task automatic test_field_extremes();
    set_order(1'b0, 1'b1);
    send_item(32'sh8000_0000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b1);
    // A sequence of one element.
    send_item(32'sh8000_0000, 1'b1);
    settle();
  endtask

  // Equal values extend a non-strict subsequence.
  task automatic test_non_strict();
    set_order(1'b0, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd5, 1'b1);
    settle();
  endtask

  task automatic test_descending();
    set_order(1'b1, 1'b1);
    send_item(32'sd10, 1'b0);
    send_item(32'sd7, 1'b0);
    send_item(32'sd7, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd20, 1'b1);
    settle();
    set_order(1'b1, 1'b0);
    send_item(32'sd4, 1'b0);
    send_item(32'sd4, 1'b0);
    send_item(32'sd2, 1'b0);
    send_item(32'sd2, 1'b1);
    settle();
  endtask

  // The store built in ascending order is searched in descending order
  // once the setting flips between two elements of the same sequence.
  task automatic test_order_change_mid_sequence();
    set_order(1'b0, 1'b1);
    send_item(32'sd1, 1'b0);
    send_item(32'sd2, 1'b0);
    send_item(32'sd3, 1'b0);
    settle();
    set_order(1'b1, 1'b1);
    send_item(32'sd2, 1'b0);
    send_item(32'sd0, 1'b1);
    settle();
  endtask

  // Fills all MAX_LEN tails, then pushes past the end. The flag must stay
  // up for the rest of the sequence and be gone in the next one.
  task automatic test_store_full();
    set_order(1'b0, 1'b1);
    for (int k = 0; k < MAX_LEN; k++) begin
      send_item(32'(k * 4 - 2000), 1'b0);
    end
    send_item(32'sd5000, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd6000, 1'b1);
    send_item(32'sd7, 1'b1);
    settle();
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // back to back, so the queue fills and input ready has to drop.
  task automatic test_backpressure();
    idle_on      = 1'b0;
    hold_request = 1'b1;
    for (int k = 0; k < 12; k++) begin
      send_item($urandom, k == 11);
    end
    settle();
    idle_on = 1'b1;
  endtask

  // Random sequences: most are closed by a last element, some carry stray
  // last flags and run on into the next one. The content is drawn from a
  // narrow range (many equal values), the full range, slow upward or
  // downward drifts that grow long subsequences, or the field extremes.
  task automatic test_random(input int items);
    int                       sent;
    int                       seq_len;
    int                       mode;
    int                       drift;
    bit                       broken;
    logic                     last;
    logic signed [DATA_W-1:0] value;
    sent = 0;
    while (sent < items) begin
      seq_len = $urandom_range(1, 48);
      mode    = $urandom_range(0, 9);
      broken  = ($urandom_range(0, 4) == 0);
      idle_on = ($urandom_range(0, 3) != 0);
      drift   = int'($urandom_range(0, 2000)) - 1000;
      for (int k = 0; k < seq_len && sent < items; k++) begin
        case (mode)
          0, 1, 2: value = int'($urandom_range(0, 16)) - 8;
          3, 4, 5: value = $urandom;
          6, 7: begin
            drift += int'($urandom_range(0, 6)) - 1;
            value = drift;
          end
          8: begin
            drift -= int'($urandom_range(0, 6)) - 1;
            value = drift;
          end
          default: begin
            case ($urandom_range(0, 4))
              0:       value = 32'sh8000_0000;
              1:       value = 32'sh7FFF_FFFF;
              2:       value = 32'sd0;
              3:       value = -32'sd1;
              default: value = $urandom;
            endcase
          end
        endcase
        if (broken) begin
          last = ($urandom_range(0, 7) == 0);
        end else begin
          last = (k == seq_len - 1);
        end
        send_item(value, last);
        sent++;
      end
    end
    settle();
    idle_on = 1'b1;
  endtask

  // Receiver: waits a drawn number of cycles before each result, then holds
  // ready high until a transfer. A hold request from the stimulus adds one
  // long stall, counted here in cycles.
  initial begin : drive_out_ready
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_request = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Checker: every output transfer is matched against the oldest
  // prediction, one field at a time.
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_lengths.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_lengths.pop_front();
        if (out_data_o.ending_length !== want.ending_length) begin
          report_mismatch($sformatf("result %0d ending_length %0d, expected %0d",
                                    results_seen, out_data_o.ending_length,
                                    want.ending_length));
        end
        if (out_data_o.best_length !== want.best_length) begin
          report_mismatch($sformatf("result %0d best_length %0d, expected %0d",
                                    results_seen, out_data_o.best_length,
                                    want.best_length));
        end
        if (out_data_o.overflow !== want.overflow) begin
          report_mismatch($sformatf("result %0d overflow %b, expected %b",
                                    results_seen, out_data_o.overflow, want.overflow));
        end
        if (out_data_o.last_out !== want.last_out) begin
          report_mismatch($sformatf("result %0d last_out %b, expected %b",
                                    results_seen, out_data_o.last_out, want.last_out));
        end
        if (want.overflow) begin
          overflow_hits++;
        end
        if (int'(want.best_length) > longest_seen) begin
          longest_seen = int'(want.best_length);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // A run that is still going at the limit has hung somewhere.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Run stopped at the cycle limit with %0d results outstanding.",
             pending_lengths.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : run_tests
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_field_extremes();
    test_non_strict();
    test_descending();
    test_order_change_mid_sequence();
    test_store_full();
    test_backpressure();
    // One random phase per order setting.
    set_order(1'b0, 1'b1);
    test_random(RANDOM_ITEMS);
    set_order(1'b0, 1'b0);
    test_random(RANDOM_ITEMS);
    set_order(1'b1, 1'b1);
    test_random(RANDOM_ITEMS);
    set_order(1'b1, 1'b0);
    test_random(RANDOM_ITEMS);
    settle();
    $display("Checked %0d results for %0d input transfers across all four order settings.",
             results_seen, items_sent);
    $display("Longest length reached %0d; %0d results carried the overflow flag.",
             longest_seen, overflow_hits);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
